// ----- hdl/ps2kd_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2kd_pkg
// Shared types, codes and layout tables for the set-1 scancode key decoder.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

  localparam logic [7:0] PREFIX_E0  = 8'hE0;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;

  localparam logic       LAYOUT_US  = 1'b0;
  localparam logic       LAYOUT_ES  = 1'b1;

  localparam logic [1:0] SIG_NONE   = 2'd0;
  localparam logic [1:0] SIG_INTR   = 2'd1;
  localparam logic [1:0] SIG_SUSP   = 2'd2;

  localparam int unsigned NAV_COUNT = 10;

  typedef struct packed {
    logic ext;
    logic shift;
    logic altgr;
    logic caps;
    logic ctrl;
    logic alt;
  } mod_state_t;

  typedef struct packed {
    logic       event_valid;
    logic       event_pressed;
    logic [7:0] event_code;
    logic       char_valid;
    logic [7:0] char_value;
    logic       keycode_valid;
    logic [4:0] keycode;
    logic [1:0] signal_code;
    logic       ctrl_held;
    logic       alt_held;
  } key_result_t;

  localparam logic [7:0] US_PLAIN [64] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] US_UPPER [64] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] ES_PLAIN [64] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'hA1, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF1,
    8'hB4, 8'hBA, 8'h00, 8'h3C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] ES_UPPER [64] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'hB7, 8'h24, 8'h25, 8'h26,
    8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'hBF, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hD1,
    8'hA8, 8'hAA, 8'h00, 8'h3E, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] ES_THIRD [8] = '{
    8'h00, 8'h00, 8'h7C, 8'h40, 8'h23, 8'h7E, 8'h80, 8'hAC
  };

  // navigation keys after the prefix: {hit, keycode}
  function automatic logic [5:0] nav_key(input logic [6:0] sc);
    logic [5:0] r;
    begin
      unique case (sc)
        7'h48:   r = {1'b1, 5'd0};
        7'h50:   r = {1'b1, 5'd1};
        7'h4B:   r = {1'b1, 5'd2};
        7'h4D:   r = {1'b1, 5'd3};
        7'h47:   r = {1'b1, 5'd4};
        7'h4F:   r = {1'b1, 5'd5};
        7'h49:   r = {1'b1, 5'd6};
        7'h51:   r = {1'b1, 5'd7};
        7'h52:   r = {1'b1, 5'd8};
        7'h53:   r = {1'b1, 5'd9};
        default: r = 6'd0;
      endcase
      return r;
    end
  endfunction

  // function keys f1 to f12: {hit, keycode}
  function automatic logic [5:0] fn_key(input logic [6:0] sc);
    logic [5:0] r;
    begin
      unique case (sc)
        7'h3B:   r = {1'b1, 5'(NAV_COUNT + 0)};
        7'h3C:   r = {1'b1, 5'(NAV_COUNT + 1)};
        7'h3D:   r = {1'b1, 5'(NAV_COUNT + 2)};
        7'h3E:   r = {1'b1, 5'(NAV_COUNT + 3)};
        7'h3F:   r = {1'b1, 5'(NAV_COUNT + 4)};
        7'h40:   r = {1'b1, 5'(NAV_COUNT + 5)};
        7'h41:   r = {1'b1, 5'(NAV_COUNT + 6)};
        7'h42:   r = {1'b1, 5'(NAV_COUNT + 7)};
        7'h43:   r = {1'b1, 5'(NAV_COUNT + 8)};
        7'h44:   r = {1'b1, 5'(NAV_COUNT + 9)};
        7'h57:   r = {1'b1, 5'(NAV_COUNT + 10)};
        7'h58:   r = {1'b1, 5'(NAV_COUNT + 11)};
        default: r = 6'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hdl/ps2kd_decode.sv -----
// ----------------------------------------------------------------------------
// ps2kd_decode
// Decode of one scancode byte against the modifier state: raw event, keycode,
// cooked character, signal code and the next modifier state.
// ----------------------------------------------------------------------------
module ps2kd_decode (
  input  logic                   layout,
  input  logic [7:0]             scan_byte,
  input  ps2kd_pkg::mod_state_t  st,
  output ps2kd_pkg::mod_state_t  st_nxt,
  output ps2kd_pkg::key_result_t res
);

  logic       pressed;
  logic [6:0] sc;
  logic [5:0] idx;
  logic       in_tab;
  logic [5:0] nav_hit;
  logic [5:0] fn_hit;
  logic       upper;
  logic [7:0] ch;
  logic       want_char;
  logic       letter;

  assign pressed = ~scan_byte[7];
  assign sc      = scan_byte[6:0];
  assign idx     = sc[5:0];
  assign in_tab  = ~sc[6];
  assign nav_hit = ps2kd_pkg::nav_key(sc);
  assign fn_hit  = ps2kd_pkg::fn_key(sc);
  assign upper   = st.shift | st.caps;

  // table lookup
  always_comb begin
    ch = 8'h00;
    if (in_tab) begin
      if (layout == ps2kd_pkg::LAYOUT_US) begin
        ch = upper ? ps2kd_pkg::US_UPPER[idx] : ps2kd_pkg::US_PLAIN[idx];
      end else if (st.altgr) begin
        ch = (idx[5:3] == 3'd0) ? ps2kd_pkg::ES_THIRD[idx[2:0]] : 8'h00;
      end else begin
        ch = upper ? ps2kd_pkg::ES_UPPER[idx] : ps2kd_pkg::ES_PLAIN[idx];
      end
    end
  end

  assign letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));

  always_comb begin
    st_nxt    = st;
    res       = '0;
    want_char = 1'b0;
    if (scan_byte == ps2kd_pkg::PREFIX_E0) begin
      st_nxt.ext = 1'b1;
    end else begin
      st_nxt.ext        = 1'b0;
      res.event_valid   = 1'b1;
      res.event_pressed = pressed;
      res.event_code    = {st.ext, sc};
      if (st.ext) begin
        if (sc == ps2kd_pkg::SC_ALT) begin
          st_nxt.altgr = pressed;
        end else if (sc == ps2kd_pkg::SC_CTRL) begin
          st_nxt.ctrl = pressed;
        end else if (pressed && nav_hit[5]) begin
          res.keycode_valid = 1'b1;
          res.keycode       = nav_hit[4:0];
        end
      end else if (sc == ps2kd_pkg::SC_LSHIFT || sc == ps2kd_pkg::SC_RSHIFT) begin
        st_nxt.shift = pressed;
      end else if (sc == ps2kd_pkg::SC_CAPS) begin
        if (pressed) begin
          st_nxt.caps = ~st.caps;
        end
      end else if (sc == ps2kd_pkg::SC_ALT) begin
        st_nxt.alt = pressed;
      end else if (sc == ps2kd_pkg::SC_CTRL) begin
        st_nxt.ctrl = pressed;
      end else if (fn_hit[5]) begin
        if (pressed) begin
          res.keycode_valid = 1'b1;
          res.keycode       = fn_hit[4:0];
        end
      end else begin
        want_char = pressed;
      end

      if (want_char && ch != 8'h00) begin
        if (st_nxt.ctrl && (ch == 8'h63 || ch == 8'h43)) begin
          res.signal_code = ps2kd_pkg::SIG_INTR;
        end else if (st_nxt.ctrl && (ch == 8'h7A || ch == 8'h5A)) begin
          res.signal_code = ps2kd_pkg::SIG_SUSP;
        end else begin
          res.char_valid = 1'b1;
          // control characters 0x01 to 0x1a
          res.char_value = (st_nxt.ctrl && letter) ? {3'b000, ch[4:0]} : ch;
        end
      end
    end
    res.ctrl_held = st_nxt.ctrl;
    res.alt_held  = st_nxt.alt;
  end

endmodule

// ----- hdl/ps2_scancode_key_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ps2_scancode_key_decoder_top
// Set-1 scancode decoder: prefix and modifier tracking, raw events, keycodes
// and cooked characters for the US or Spanish layout.
// ----------------------------------------------------------------------------
// an accepted item passes the input register, then the result register, before out_valid rises
// throughput: one item per cycle while out_stall is low, one result per item
// while a result waits on out_stall the input register takes one more item,
// then in_stall rises until the result goes
// reset (synchronous, rst_n low) clears the prefix and modifier state,
// empties both registers and selects the Spanish layout
module ps2_scancode_key_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_event_valid,
  output logic       out_event_pressed,
  output logic [7:0] out_event_code,
  output logic       out_char_valid,
  output logic [7:0] out_char_value,
  output logic       out_keycode_valid,
  output logic [4:0] out_keycode,
  output logic [1:0] out_signal_code,
  output logic       out_ctrl_held,
  output logic       out_alt_held
);

  logic                  layout_r;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [7:0]            s1_byte_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  ps2kd_pkg::key_result_t res_r;
  ps2kd_pkg::key_result_t res_nxt;
  ps2kd_pkg::mod_state_t  st_r;
  ps2kd_pkg::mod_state_t  st_nxt;
  logic                  adv;
  logic                  accept;

  assign adv      = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign accept   = in_valid & ~in_stall;

  ps2kd_decode u_decode (
    .layout    (layout_r),
    .scan_byte (s1_byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_comb begin
    s1_valid_nxt  = accept | (s1_valid_r & ~adv);
    out_valid_nxt = adv | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r    <= ps2kd_pkg::LAYOUT_ES;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        layout_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_scan_byte;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_valid   = res_r.event_valid;
  assign out_event_pressed = res_r.event_pressed;
  assign out_event_code    = res_r.event_code;
  assign out_char_valid    = res_r.char_valid;
  assign out_char_value    = res_r.char_value;
  assign out_keycode_valid = res_r.keycode_valid;
  assign out_keycode       = res_r.keycode;
  assign out_signal_code   = res_r.signal_code;
  assign out_ctrl_held     = res_r.ctrl_held;
  assign out_alt_held      = res_r.alt_held;

endmodule

// ----- hdl/ps2kd_checker.sv -----
// ----------------------------------------------------------------------------
// ps2kd_checker
// Port-level checks on the result channel of the scancode decoder.
// ----------------------------------------------------------------------------
module ps2kd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_event_valid,
  input logic       out_event_pressed,
  input logic [7:0] out_event_code,
  input logic       out_char_valid,
  input logic [7:0] out_char_value,
  input logic       out_keycode_valid,
  input logic [4:0] out_keycode,
  input logic [1:0] out_signal_code
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_value)
      && $stable(out_event_code) && $stable(out_keycode))
    else $error("result changed while stalled");

  // prefix item carries nothing
  a_prefix_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> !out_event_pressed && out_event_code == 8'h00
      && !out_char_valid && !out_keycode_valid && out_signal_code == 2'd0)
    else $error("prefix item carries an event");

  // keycode only on a press, never with a character
  a_keycode_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keycode_valid |-> out_event_pressed && !out_char_valid
      && out_keycode <= 5'd21)
    else $error("bad keycode item");

  // a character and a signal never share an item, and a character is never zero
  a_char_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_signal_code == 2'd0 && out_char_value != 8'h00)
    else $error("character with signal or zero value");

endmodule

bind ps2_scancode_key_decoder_top ps2kd_checker u_ps2kd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_event_valid   (out_event_valid),
  .out_event_pressed (out_event_pressed),
  .out_event_code    (out_event_code),
  .out_char_valid    (out_char_valid),
  .out_char_value    (out_char_value),
  .out_keycode_valid (out_keycode_valid),
  .out_keycode       (out_keycode),
  .out_signal_code   (out_signal_code)
);

// ----- tb/sv/ps2kd_result_checker.sv -----
// ----------------------------------------------------------------------------
// ps2kd_result_checker
// Watches both channels of the scancode decoder, decodes every accepted
// scancode byte in step with the block and compares each result item with
// the oldest decode still waiting.
// ----------------------------------------------------------------------------
module ps2kd_result_checker
  import ps2kd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_scan_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_event_valid,
  input  logic       out_event_pressed,
  input  logic [7:0] out_event_code,
  input  logic       out_char_valid,
  input  logic [7:0] out_char_value,
  input  logic       out_keycode_valid,
  input  logic [4:0] out_keycode,
  input  logic [1:0] out_signal_code,
  input  logic       out_ctrl_held,
  input  logic       out_alt_held,
  output int         fail_count,
  output int         decodes_in_flight
);

  localparam logic [7:0] US_LO [64] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] US_UP [64] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] ES_LO [64] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'hA1, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF1,
    8'hB4, 8'hBA, 8'h00, 8'h3C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] ES_UP [64] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'hB7, 8'h24, 8'h25, 8'h26,
    8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'hBF, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hD1,
    8'hA8, 8'hAA, 8'h00, 8'h3E, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] ES_LVL3 [8] = '{
    8'h00, 8'h00, 8'h7C, 8'h40, 8'h23, 8'h7E, 8'h80, 8'hAC
  };
  localparam logic [6:0] NAV_SCANS [10] = '{
    7'h48, 7'h50, 7'h4B, 7'h4D, 7'h47, 7'h4F, 7'h49, 7'h51, 7'h52, 7'h53
  };
  localparam logic [6:0] FN_SCANS [12] = '{
    7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h57, 7'h58
  };

  logic        layout_q  = LAYOUT_ES;
  mod_state_t  keys_q    = '0;
  key_result_t decoded_q [$];
  key_result_t got_key;
  key_result_t want_key;
  int          bad_count = 0;
  int          result_no = 0;

  initial begin
    fail_count        = 0;
    decodes_in_flight = 0;
  end

  function automatic key_result_t decode_scan(input logic [7:0] scan);
    key_result_t r;
    logic        pressed;
    logic [6:0]  sc;
    logic        was_ext;
    logic        upper;
    logic        is_fn;
    logic        letter;
    logic [7:0]  ch;
    r  = '0;
    ch = 8'h00;
    if (scan == PREFIX_E0) begin
      keys_q.ext = 1'b1;
    end else begin
      pressed    = ~scan[7];
      sc         = scan[6:0];
      was_ext    = keys_q.ext;
      keys_q.ext = 1'b0;
      r.event_valid   = 1'b1;
      r.event_pressed = pressed;
      r.event_code    = {was_ext, sc};
      if (was_ext) begin
        if (sc == SC_ALT) begin
          keys_q.altgr = pressed;
        end else if (sc == SC_CTRL) begin
          keys_q.ctrl = pressed;
        end else if (pressed) begin
          for (int i = 0; i < 10; i++) begin
            if (NAV_SCANS[i] == sc) begin
              r.keycode_valid = 1'b1;
              r.keycode       = 5'(i);
            end
          end
        end
      end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
        keys_q.shift = pressed;
      end else if (sc == SC_CAPS) begin
        if (pressed) keys_q.caps = ~keys_q.caps;
      end else if (sc == SC_ALT) begin
        keys_q.alt = pressed;
      end else if (sc == SC_CTRL) begin
        keys_q.ctrl = pressed;
      end else begin
        is_fn = 1'b0;
        for (int i = 0; i < 12; i++) begin
          if (FN_SCANS[i] == sc) begin
            is_fn = 1'b1;
            if (pressed) begin
              r.keycode_valid = 1'b1;
              r.keycode       = 5'(NAV_COUNT + i);
            end
          end
        end
        if (!is_fn && pressed && sc < 7'h40) begin
          upper = keys_q.shift | keys_q.caps;
          if (layout_q == LAYOUT_US) begin
            ch = upper ? US_UP[sc[5:0]] : US_LO[sc[5:0]];
          end else if (keys_q.altgr) begin
            ch = (sc < 7'h08) ? ES_LVL3[sc[2:0]] : 8'h00;
          end else begin
            ch = upper ? ES_UP[sc[5:0]] : ES_LO[sc[5:0]];
          end
        end
      end
      if (ch != 8'h00) begin
        letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
        if (keys_q.ctrl && (ch == "c" || ch == "C")) begin
          r.signal_code = SIG_INTR;
        end else if (keys_q.ctrl && (ch == "z" || ch == "Z")) begin
          r.signal_code = SIG_SUSP;
        end else begin
          if (keys_q.ctrl && letter) ch = (ch | 8'h20) - 8'h60;
          r.char_valid = 1'b1;
          r.char_value = ch;
        end
      end
    end
    r.ctrl_held = keys_q.ctrl;
    r.alt_held  = keys_q.alt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      layout_q = LAYOUT_ES;
      keys_q   = '0;
      decoded_q.delete();
    end else begin
      if (cfg_wr_en) layout_q = cfg_wr_data;
      if (out_valid && !out_stall) begin
        got_key = {out_event_valid, out_event_pressed, out_event_code, out_char_valid,
                   out_char_value, out_keycode_valid, out_keycode, out_signal_code,
                   out_ctrl_held, out_alt_held};
        if (decoded_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("result %0d arrived with no item waiting", result_no);
        end else begin
          want_key = decoded_q.pop_front();
          if (got_key !== want_key) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("result %0d mismatch", result_no);
              $display("  expected ev %b/%b/%h ch %b/%h kc %b/%0d sig %0d ctrl %b alt %b",
                       want_key.event_valid, want_key.event_pressed, want_key.event_code,
                       want_key.char_valid, want_key.char_value, want_key.keycode_valid,
                       want_key.keycode, want_key.signal_code, want_key.ctrl_held,
                       want_key.alt_held);
              $display("  actual   ev %b/%b/%h ch %b/%h kc %b/%0d sig %0d ctrl %b alt %b",
                       got_key.event_valid, got_key.event_pressed, got_key.event_code,
                       got_key.char_valid, got_key.char_value, got_key.keycode_valid,
                       got_key.keycode, got_key.signal_code, got_key.ctrl_held,
                       got_key.alt_held);
            end
          end
        end
        result_no++;
      end
      if (in_valid && !in_stall) decoded_q.push_back(decode_scan(in_scan_byte));
    end
    decodes_in_flight <= decoded_q.size();
    fail_count        <= bad_count;
  end

endmodule

// ----- tb/sv/ps2_scancode_key_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// ps2_scancode_key_decoder_top_tb
// Drives scancode bytes into the decoder in bursts, with a short directed
// opening and then random keystrokes under both layouts, while the result
// side stalls in changing patterns; a side checker decodes and compares.
// ----------------------------------------------------------------------------
module ps2_scancode_key_decoder_top_tb;
  import ps2kd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_RUNS   = 2;

  localparam logic [6:0] NAV_KEYS [10] = '{
    7'h48, 7'h50, 7'h4B, 7'h4D, 7'h47, 7'h4F, 7'h49, 7'h51, 7'h52, 7'h53
  };
  localparam logic [6:0] FN_KEYS [12] = '{
    7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h57, 7'h58
  };
  localparam logic [6:0] MOD_KEYS [5] = '{SC_LSHIFT, SC_RSHIFT, SC_CAPS, SC_ALT, SC_CTRL};
  localparam logic [7:0] OPENING [29] = '{
    8'h00, 8'hFF, 8'h1E, 8'h2A, 8'h02, 8'hAA, 8'h3A, 8'h1E, 8'h3A, 8'hE0,
    8'h38, 8'h03, 8'hE0, 8'hB8, 8'h1D, 8'h2E, 8'h2C, 8'h1F, 8'h9D, 8'h38,
    8'h3B, 8'hBB, 8'hB8, 8'hE0, 8'h53, 8'hE0, 8'hE0, 8'h48, 8'h7F
  };

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_wr_en    = 1'b0;
  logic       cfg_wr_data  = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_event_valid;
  logic       out_event_pressed;
  logic [7:0] out_event_code;
  logic       out_char_valid;
  logic [7:0] out_char_value;
  logic       out_keycode_valid;
  logic [4:0] out_keycode;
  logic [1:0] out_signal_code;
  logic       out_ctrl_held;
  logic       out_alt_held;

  int fail_count;
  int decodes_in_flight;
  int burst_left  = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;
  int stall_mode  = STALL_NONE;
  logic [5:0] stall_tick = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ps2_scancode_key_decoder_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_scan_byte      (in_scan_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_valid   (out_event_valid),
    .out_event_pressed (out_event_pressed),
    .out_event_code    (out_event_code),
    .out_char_valid    (out_char_valid),
    .out_char_value    (out_char_value),
    .out_keycode_valid (out_keycode_valid),
    .out_keycode       (out_keycode),
    .out_signal_code   (out_signal_code),
    .out_ctrl_held     (out_ctrl_held),
    .out_alt_held      (out_alt_held)
  );

  ps2kd_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_scan_byte      (in_scan_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_valid   (out_event_valid),
    .out_event_pressed (out_event_pressed),
    .out_event_code    (out_event_code),
    .out_char_valid    (out_char_valid),
    .out_char_value    (out_char_value),
    .out_keycode_valid (out_keycode_valid),
    .out_keycode       (out_keycode),
    .out_signal_code   (out_signal_code),
    .out_ctrl_held     (out_ctrl_held),
    .out_alt_held      (out_alt_held),
    .fail_count        (fail_count),
    .decodes_in_flight (decodes_in_flight)
  );

  // result side stall pattern, mode picked anew each time stall_tick wraps
  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= (stall_tick[3:0] >= 4'd9);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_scan(input logic [7:0] scan);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_scan_byte <= scan;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (decodes_in_flight != 0);
  endtask

  task automatic write_layout(input logic layout);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= layout;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_keystroke();
    int         pick;
    logic [6:0] sc;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_scan(8'($urandom_range(0, 255)));
    end else if (pick < 50) begin
      sc = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, 57));
      send_scan({1'b0, sc});
      send_scan({1'b1, sc});
    end else if (pick < 66) begin
      sc = MOD_KEYS[$urandom_range(0, 4)];
      if ((sc == SC_ALT || sc == SC_CTRL) && $urandom_range(0, 1) == 1)
        send_scan(PREFIX_E0);
      send_scan({1'($urandom_range(0, 1)), sc});
    end else if (pick < 84) begin
      send_scan(PREFIX_E0);
      if ($urandom_range(0, 3) != 0) begin
        sc = NAV_KEYS[$urandom_range(0, 9)];
        send_scan({1'b0, sc});
        send_scan(PREFIX_E0);
        send_scan({1'b1, sc});
      end else begin
        send_scan(8'($urandom_range(0, 255)));
      end
    end else begin
      sc = FN_KEYS[$urandom_range(0, 11)];
      send_scan({1'b0, sc});
      send_scan({1'b1, sc});
    end
  endtask

  task automatic run_phase(input logic layout, input int count);
    int stop_at;
    wait_drained();
    write_layout(layout);
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      send_keystroke();
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (OPENING[i]) send_scan(OPENING[i]);
    run_phase(LAYOUT_US, 150);
    run_phase(LAYOUT_ES, 150);
    run_phase(LAYOUT_US, 150);
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ps2kd_pkg.sv
hdl/ps2kd_decode.sv
hdl/ps2_scancode_key_decoder_top.sv
hdl/ps2kd_checker.sv
tb/sv/ps2kd_result_checker.sv
tb/sv/ps2_scancode_key_decoder_top_tb.sv
